### src/link_end_msd_lag_accumulator_assert.svh
// Assertion macros for the accumulator RTL, used by lema_back.
// Each expects clk_i and rst_ni in scope.
`ifndef LINK_END_MSD_LAG_ACCUMULATOR_ASSERT_SVH
`define LINK_END_MSD_LAG_ACCUMULATOR_ASSERT_SVH

// Assert that a property holds at every clock edge outside reset.
`define LEMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition never holds outside reset.
`define LEMA_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### src/lema_pkg.sv
// ---------------------------------------------------------------------------
// lema_pkg
// Types and constants of the link-end lag accumulator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lema_pkg;

  localparam int unsigned LAG_BINS_DEF   = 1024;
  localparam int unsigned LINK_SLOTS_DEF = 1024;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned DIV_STEPS      = 32;

  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [47:0] SUM_MAX = '1;
  localparam logic [31:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_CLEAR,
    OP_READ,
    OP_READ_ZERO
  } op_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [9:0]  link_tag;
    logic [31:0] step_time;
    logic [15:0] pos_end0;
    logic [15:0] pos_end1;
    logic [9:0]  lag_bin;
  } in_t;

  typedef struct packed {
    logic [47:0] sum_sq_disp;
    logic [31:0] sample_count;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [9:0]  tag;
    logic [31:0] step;
    logic [15:0] pos0;
    logic [15:0] pos1;
    logic [9:0]  bin;
  } cmd_t;

endpackage
`default_nettype wire

### src/link_end_msd_lag_accumulator.sv
// ---------------------------------------------------------------------------
// link_end_msd_lag_accumulator
// Squared displacement sums per lag bin for the two ends of slip links.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  in       | input     | in_valid_i / in_ready_o  | in_data_i  (lema_pkg::in_t)
//  out      | output    | out_valid_o / out_ready_i| out_data_o (lema_pkg::out_t)
//  cfg      | input     | cfg_valid_i / cfg_ready_o| cfg_data_i (sample interval)
//
//  After reset a clearing pass over all origin slots and lag bins runs;
//  requests wait, configuration writes are taken.
//  The back part takes each request in its idle state. Sample: per link end an
//  origin lookup; an end with no origin records it, one that bins waits on the
//  bit-serial lag divider and a bin read-modify-write; a long lag drops the end;
//  clear drops both origins; read gives the bin or zero; then the output register.
//  A waiting result holds the back part in its response state; the queue and
//  front stage then fill and hold off the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module link_end_msd_lag_accumulator #(
  parameter int unsigned LAG_BINS   = lema_pkg::LAG_BINS_DEF,
  parameter int unsigned LINK_SLOTS = lema_pkg::LINK_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lema_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lema_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [15:0]    cfg_data_i
);

  logic           cfg_we;
  logic [15:0]    sample_interval_q;
  logic           busy;
  logic           f_valid, f_ready, b_valid, b_ready;
  lema_pkg::cmd_t f_cmd, b_cmd;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_interval_q <= 16'd1;
    end else if (cfg_we) begin
      sample_interval_q <= cfg_data_i;
    end
  end

  lema_front #(
    .LAG_BINS   (LAG_BINS),
    .LINK_SLOTS (LINK_SLOTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .busy_i      (busy),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  lema_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  lema_back #(
    .LAG_BINS   (LAG_BINS),
    .LINK_SLOTS (LINK_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .interval_i  (sample_interval_q),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

### src/lema_front.sv
// ---------------------------------------------------------------------------
// lema_front
// Accepts requests, drops those with no effect and classifies the rest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lema_front #(
  parameter int unsigned LAG_BINS   = lema_pkg::LAG_BINS_DEF,
  parameter int unsigned LINK_SLOTS = lema_pkg::LINK_SLOTS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire lema_pkg::in_t in_data_i,
  input  wire logic          busy_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output lema_pkg::cmd_t     cmd_o
);

  logic           fv_q, fv_d;
  lema_pkg::cmd_t cmd_q;
  lema_pkg::cmd_t cls;
  logic           keep;
  logic           tag_ok, bin_ok;

  assign tag_ok = 32'(in_data_i.link_tag) < 32'(LINK_SLOTS);
  assign bin_ok = 32'(in_data_i.lag_bin) < 32'(LAG_BINS);

  always_comb begin
    cls.tag  = in_data_i.link_tag;
    cls.step = in_data_i.step_time;
    cls.pos0 = in_data_i.pos_end0;
    cls.pos1 = in_data_i.pos_end1;
    cls.bin  = in_data_i.lag_bin;
    cls.op   = lema_pkg::OP_SAMPLE;
    keep     = 1'b0;
    unique case (in_data_i.action)
      lema_pkg::ACT_SAMPLE: begin
        cls.op = lema_pkg::OP_SAMPLE;
        keep   = tag_ok;
      end
      lema_pkg::ACT_CLEAR: begin
        cls.op = lema_pkg::OP_CLEAR;
        keep   = tag_ok;
      end
      lema_pkg::ACT_READ: begin
        cls.op = bin_ok ? lema_pkg::OP_READ : lema_pkg::OP_READ_ZERO;
        keep   = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o  = !busy_i && (!fv_q || cmd_ready_i);
  assign cmd_valid_o = fv_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    fv_d = fv_q;
    if (in_valid_i && in_ready_o) begin
      fv_d = keep;
    end else if (cmd_ready_i) begin
      fv_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  // hold the request until the queue takes it
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cls;
    end
  end

endmodule
`default_nettype wire

### src/lema_queue.sv
// ---------------------------------------------------------------------------
// lema_queue
// Short request queue between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lema_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire lema_pkg::cmd_t push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output lema_pkg::cmd_t      pop_data_o
);

  localparam int unsigned Depth = lema_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  lema_pkg::cmd_t    slot_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != CntW'(Depth);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### src/lema_div.sv
// ---------------------------------------------------------------------------
// lema_div
// Restoring divider, one quotient bit per cycle, for lag over interval.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lema_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  localparam int unsigned CntW = $clog2(lema_pkg::DIV_STEPS);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [15:0]     rem_q, dvs_q;
  logic [31:0]     quo_q;
  logic [16:0]     trial;
  logic            fits;

  assign trial  = {rem_q, quo_q[31]};
  assign fits   = trial >= {1'b0, dvs_q};
  assign done_o = done_q;
  assign quot_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(lema_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 16'(trial - {1'b0, dvs_q}) : trial[15:0];
      quo_q <= {quo_q[30:0], fits};
    end
  end

endmodule
`default_nettype wire

### src/lema_back.sv
// ---------------------------------------------------------------------------
// lema_back
// Carries out queued requests: origin lookup, lag binning, bin update, clears, reads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lema_back #(
  parameter int unsigned LAG_BINS   = lema_pkg::LAG_BINS_DEF,
  parameter int unsigned LINK_SLOTS = lema_pkg::LINK_SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  output logic                cmd_ready_o,
  input  wire lema_pkg::cmd_t cmd_i,
  input  wire logic [15:0]    interval_i,
  output logic                busy_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lema_pkg::out_t      out_data_o
);

  `include "link_end_msd_lag_accumulator_assert.svh"

  localparam int unsigned Slots = 2 * LINK_SLOTS;
  localparam int unsigned SW    = $clog2(Slots);
  localparam int unsigned BW    = (LAG_BINS > 1) ? $clog2(LAG_BINS) : 1;
  localparam int unsigned Sweep = (Slots > LAG_BINS) ? Slots : LAG_BINS;
  localparam int unsigned CW    = $clog2(Sweep);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_OREQ, S_OCHK, S_DIV, S_BREQ, S_BCHK, S_CLR, S_RESP
  } state_e;

  state_e         state_q;
  lema_pkg::cmd_t cmd_q;
  logic           end_q;
  logic [CW-1:0]  sweep_q;
  logic [BW-1:0]  baddr_q;
  logic [15:0]    diff_q;
  logic [31:0]    sq_q;
  lema_pkg::out_t resp_q;
  logic           out_valid_q;
  lema_pkg::out_t out_data_q;

  // origin stores
  logic           ovalid_mem [Slots];
  logic [31:0]    ostep_mem  [Slots];
  logic [15:0]    opos_mem   [Slots];
  logic           ovalid_rd;
  logic [31:0]    ostep_rd;
  logic [15:0]    opos_rd;
  // bin stores
  logic [47:0]    bsum_mem [LAG_BINS];
  logic [31:0]    bcnt_mem [LAG_BINS];
  logic [47:0]    bsum_rd;
  logic [31:0]    bcnt_rd;

  logic [SW-1:0]  slot;
  logic           o_re, ov_we, ov_wd, od_we;
  logic [SW-1:0]  o_waddr;
  logic           b_re, b_we;
  logic [BW-1:0]  b_waddr;
  logic [47:0]    b_wsum;
  logic [31:0]    b_wcnt;
  logic [15:0]    pos;
  logic [48:0]    sum_ext;
  logic           div_start, div_done;
  logic [31:0]    quot;
  logic [15:0]    divisor;
  logic           out_free;
  logic           in_sweep_o, in_sweep_b;

  assign slot        = SW'({cmd_q.tag, end_q});
  assign pos         = end_q ? cmd_q.pos1 : cmd_q.pos0;
  assign divisor     = (interval_i == '0) ? 16'd1 : interval_i;
  assign sum_ext     = {1'b0, bsum_rd} + {17'b0, sq_q};
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_sweep_o  = {1'b0, sweep_q} < (CW + 1)'(Slots);
  assign in_sweep_b  = {1'b0, sweep_q} < (CW + 1)'(LAG_BINS);
  assign cmd_ready_o = state_q == S_IDLE;
  assign busy_o      = state_q == S_INIT;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign div_start   = state_q == S_OCHK && ovalid_rd;

  lema_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cmd_q.step - ostep_rd),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  always_comb begin
    o_re    = 1'b0;
    ov_we   = 1'b0;
    ov_wd   = 1'b0;
    od_we   = 1'b0;
    o_waddr = slot;
    b_re    = 1'b0;
    b_we    = 1'b0;
    b_waddr = baddr_q;
    b_wsum  = (sum_ext[48]) ? lema_pkg::SUM_MAX : sum_ext[47:0];
    b_wcnt  = (bcnt_rd == lema_pkg::CNT_MAX) ? bcnt_rd : bcnt_rd + 32'd1;
    unique case (state_q)
      S_INIT: begin
        o_waddr = SW'(sweep_q);
        b_waddr = BW'(sweep_q);
        ov_we   = in_sweep_o;
        b_we    = in_sweep_b;
        b_wsum  = '0;
        b_wcnt  = '0;
      end
      S_OREQ: o_re = 1'b1;
      S_OCHK: begin
        // an end with no origin records this one
        ov_we = !ovalid_rd;
        ov_wd = 1'b1;
        od_we = !ovalid_rd;
      end
      S_BREQ: b_re = 1'b1;
      S_BCHK: b_we = cmd_q.op == lema_pkg::OP_SAMPLE;
      S_CLR:  ov_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ov_we) begin
      ovalid_mem[o_waddr] <= ov_wd;
    end
    if (o_re) begin
      ovalid_rd <= ovalid_mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (od_we) begin
      ostep_mem[o_waddr] <= cmd_q.step;
      opos_mem[o_waddr]  <= pos;
    end
    if (o_re) begin
      ostep_rd <= ostep_mem[slot];
      opos_rd  <= opos_mem[slot];
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_we) begin
      bsum_mem[b_waddr] <= b_wsum;
      bcnt_mem[b_waddr] <= b_wcnt;
    end
    if (b_re) begin
      bsum_rd <= bsum_mem[baddr_q];
      bcnt_rd <= bcnt_mem[baddr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      sweep_q     <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      baddr_q     <= '0;
      diff_q      <= '0;
      sq_q        <= '0;
      resp_q      <= '0;
      out_data_q  <= '0;
    end else begin
      if (state_q == S_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_INIT: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == CW'(Sweep - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            end_q   <= 1'b0;
            baddr_q <= BW'(cmd_i.bin);
            resp_q  <= '0;
            unique case (cmd_i.op)
              lema_pkg::OP_SAMPLE:    state_q <= S_OREQ;
              lema_pkg::OP_CLEAR:     state_q <= S_CLR;
              lema_pkg::OP_READ:      state_q <= S_BREQ;
              lema_pkg::OP_READ_ZERO: state_q <= S_RESP;
              default:                state_q <= S_IDLE;
            endcase
          end
        end
        S_OREQ: state_q <= S_OCHK;
        S_OCHK: begin
          diff_q <= (pos >= opos_rd) ? pos - opos_rd : opos_rd - pos;
          if (ovalid_rd) begin
            state_q <= S_DIV;
          end else if (!end_q) begin
            end_q   <= 1'b1;
            state_q <= S_OREQ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIV: begin
          sq_q <= diff_q * diff_q;
          if (div_done) begin
            if (quot < 32'(LAG_BINS)) begin
              baddr_q <= BW'(quot);
              state_q <= S_BREQ;
            end else if (!end_q) begin
              // lag too long: drop this end
              end_q   <= 1'b1;
              state_q <= S_OREQ;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        S_BREQ: state_q <= S_BCHK;
        S_BCHK: begin
          if (cmd_q.op == lema_pkg::OP_READ) begin
            resp_q  <= '{sum_sq_disp: bsum_rd, sample_count: bcnt_rd};
            state_q <= S_RESP;
          end else if (!end_q) begin
            end_q   <= 1'b1;
            state_q <= S_OREQ;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_CLR: begin
          end_q   <= 1'b1;
          state_q <= end_q ? S_IDLE : S_CLR;
        end
        S_RESP: begin
          if (out_free) begin
            out_data_q <= resp_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `LEMA_NEVER(a_no_pop_in_sweep, state_q == S_INIT && cmd_ready_o,
    "request taken during clearing pass")
  `LEMA_NEVER(a_div_done_state, div_done && state_q != S_DIV,
    "divider finished outside its wait state")
  `LEMA_ASSERT(a_bin_addr_range, b_we |-> 32'(b_waddr) < 32'(LAG_BINS),
    "bin write beyond last bin")
  `LEMA_ASSERT(a_resp_loads_out, state_q == S_RESP && out_free |=> out_valid_q,
    "read response not presented")

endmodule
`default_nettype wire
